// ----- rtl/rqs_pkg.sv -----
// Package for the quicksort sorter: sizes, transaction types and sequencer states.
package rqs_pkg;

  localparam int MAX_ITEMS = 32;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] sorted_value;
    logic                     final_res;
    logic                     dropped;
  } out_t;

  typedef struct packed {
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
  } range_t;

  typedef enum logic [3:0] {
    S_LOAD,
    S_POP,
    S_POPD,
    S_PIVW,
    S_PRD,
    S_PCMP,
    S_SW1,
    S_SW2,
    S_FIN1,
    S_FIN2,
    S_PUSHL,
    S_PUSHR,
    S_ORD,
    S_OUT
  } state_t;

endpackage

// ----- rtl/rqs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/randomized_quicksort_sorter.sv -----
// Top level of the quicksort sorter: load, in-place partition sequencer and ordered readout.
//
// Values load at one transaction per cycle, while in_stall is low, into a 32-entry store; a
// value past capacity is dropped and flags every result of that set. The transaction marked
// last starts the sort, during which in_stall stays high. The sort is quicksort with an
// explicit range stack in a small RAM; all work goes through one store RAM port pair and one
// signed comparator, so a partition step compares one element at a time with the pivot and
// swaps each one that is not above it into the lower part. The pivot is the last element of
// each range, so values that arrive already ordered or mostly equal give the worst case. The
// sorted set then leaves one result at a time, each read from the store before it is offered,
// and is held while out_stall is high. No clearing pass is needed after reset.
module randomized_quicksort_sorter (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rqs_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rqs_pkg::out_t out_data
);

  localparam int IDX_W = rqs_pkg::IDX_W;
  localparam int CNT_W = rqs_pkg::CNT_W;
  localparam int DW    = rqs_pkg::DATA_W;
  localparam int RW    = $bits(rqs_pkg::range_t);

  rqs_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic             ovf_r, ovf_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [IDX_W-1:0] j_r, j_nxt, st_r, st_nxt, k_r, k_nxt;
  logic signed [DW-1:0] pv_r, pv_nxt, tmp_r, tmp_nxt;

  logic             s_we, s_re;
  logic [IDX_W-1:0] s_waddr, s_raddr;
  logic [DW-1:0]    s_wdata, s_rdata;
  logic             k_we, k_re;
  logic [IDX_W-1:0] k_waddr, k_raddr;
  rqs_pkg::range_t  k_wdata, k_rd;
  logic [RW-1:0]    k_rdata;

  logic             in_acc, out_acc, le;
  logic [IDX_W-1:0] lsz, rsz;

  assign k_rd   = rqs_pkg::range_t'(k_rdata);
  assign in_acc = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign le     = $signed(s_rdata) <= pv_r;
  assign lsz    = st_r - lo_r;
  assign rsz    = hi_r - st_r;

  rqs_ram #(.WIDTH(DW), .DEPTH(rqs_pkg::MAX_ITEMS)) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .re    (s_re),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  rqs_ram #(.WIDTH(RW), .DEPTH(rqs_pkg::MAX_ITEMS)) u_stack (
    .clk   (clk),
    .we    (k_we),
    .waddr (k_waddr),
    .wdata (k_wdata),
    .re    (k_re),
    .raddr (k_raddr),
    .rdata (k_rdata)
  );

  assign in_stall  = (state_r != rqs_pkg::S_LOAD);
  assign out_valid = (state_r == rqs_pkg::S_OUT);
  assign out_data.sorted_value = $signed(s_rdata);
  assign out_data.final_res    = ((CNT_W'(k_r) + CNT_W'(1)) == cnt_r);
  assign out_data.dropped      = ovf_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    sp_nxt    = sp_r;
    ovf_nxt   = ovf_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    j_nxt     = j_r;
    st_nxt    = st_r;
    k_nxt     = k_r;
    pv_nxt    = pv_r;
    tmp_nxt   = tmp_r;
    s_we      = 1'b0;
    s_waddr   = j_r;
    s_wdata   = s_rdata;
    s_re      = 1'b0;
    s_raddr   = j_r;
    k_we      = 1'b0;
    k_waddr   = sp_r[IDX_W-1:0];
    k_wdata   = '{lo: lo_r, hi: hi_r};
    k_re      = 1'b0;
    k_raddr   = sp_r[IDX_W-1:0] - IDX_W'(1);
    case (state_r)
      rqs_pkg::S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(rqs_pkg::MAX_ITEMS)) begin
            s_we    = 1'b1;
            s_waddr = cnt_r[IDX_W-1:0];
            s_wdata = in_data.value;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last) begin
            k_nxt = '0;
            if (cnt_nxt >= CNT_W'(2)) begin
              k_we      = 1'b1;
              k_waddr   = '0;
              k_wdata   = '{lo: '0, hi: IDX_W'(cnt_nxt - CNT_W'(1))};
              sp_nxt    = CNT_W'(1);
              state_nxt = rqs_pkg::S_POP;
            end else begin
              state_nxt = rqs_pkg::S_ORD;
            end
          end
        end
      end
      rqs_pkg::S_POP: begin
        k_re      = 1'b1;
        sp_nxt    = sp_r - CNT_W'(1);
        state_nxt = rqs_pkg::S_POPD;
      end
      rqs_pkg::S_POPD: begin
        lo_nxt    = k_rd.lo;
        hi_nxt    = k_rd.hi;
        s_re      = 1'b1;
        s_raddr   = k_rd.hi;
        state_nxt = rqs_pkg::S_PIVW;
      end
      rqs_pkg::S_PIVW: begin
        pv_nxt    = $signed(s_rdata);
        j_nxt     = lo_r;
        st_nxt    = lo_r;
        state_nxt = rqs_pkg::S_PRD;
      end
      rqs_pkg::S_PRD: begin
        s_re = 1'b1;
        if (j_r == hi_r) begin
          s_raddr   = st_r;
          state_nxt = rqs_pkg::S_FIN1;
        end else begin
          s_raddr   = j_r;
          state_nxt = rqs_pkg::S_PCMP;
        end
      end
      rqs_pkg::S_PCMP: begin
        if (le && (st_r != j_r)) begin
          tmp_nxt   = $signed(s_rdata);
          s_re      = 1'b1;
          s_raddr   = st_r;
          state_nxt = rqs_pkg::S_SW1;
        end else begin
          if (le) begin
            st_nxt = st_r + IDX_W'(1);
          end
          j_nxt     = j_r + IDX_W'(1);
          state_nxt = rqs_pkg::S_PRD;
        end
      end
      rqs_pkg::S_SW1: begin
        s_we      = 1'b1;
        s_waddr   = j_r;
        s_wdata   = s_rdata;
        state_nxt = rqs_pkg::S_SW2;
      end
      rqs_pkg::S_SW2: begin
        s_we      = 1'b1;
        s_waddr   = st_r;
        s_wdata   = tmp_r;
        st_nxt    = st_r + IDX_W'(1);
        j_nxt     = j_r + IDX_W'(1);
        state_nxt = rqs_pkg::S_PRD;
      end
      rqs_pkg::S_FIN1: begin
        s_we      = 1'b1;
        s_waddr   = hi_r;
        s_wdata   = s_rdata;
        state_nxt = rqs_pkg::S_FIN2;
      end
      rqs_pkg::S_FIN2: begin
        s_we      = 1'b1;
        s_waddr   = st_r;
        s_wdata   = pv_r;
        state_nxt = rqs_pkg::S_PUSHL;
      end
      rqs_pkg::S_PUSHL: begin
        if (lsz >= IDX_W'(2)) begin
          k_we    = 1'b1;
          k_wdata = '{lo: lo_r, hi: st_r - IDX_W'(1)};
          sp_nxt  = sp_r + CNT_W'(1);
        end
        state_nxt = rqs_pkg::S_PUSHR;
      end
      rqs_pkg::S_PUSHR: begin
        if (rsz >= IDX_W'(2)) begin
          k_we    = 1'b1;
          k_wdata = '{lo: st_r + IDX_W'(1), hi: hi_r};
          sp_nxt  = sp_r + CNT_W'(1);
        end
        if (sp_nxt != '0) begin
          state_nxt = rqs_pkg::S_POP;
        end else begin
          state_nxt = rqs_pkg::S_ORD;
        end
      end
      rqs_pkg::S_ORD: begin
        s_re      = 1'b1;
        s_raddr   = k_r;
        state_nxt = rqs_pkg::S_OUT;
      end
      rqs_pkg::S_OUT: begin
        if (!out_stall) begin
          if (out_data.final_res) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = rqs_pkg::S_LOAD;
          end else begin
            k_nxt     = k_r + IDX_W'(1);
            state_nxt = rqs_pkg::S_ORD;
          end
        end
      end
      default: begin
        state_nxt = rqs_pkg::S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rqs_pkg::S_LOAD;
      cnt_r   <= '0;
      sp_r    <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      sp_r    <= sp_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r  <= lo_nxt;
    hi_r  <= hi_nxt;
    j_r   <= j_nxt;
    st_r  <= st_nxt;
    k_r   <= k_nxt;
    pv_r  <= pv_nxt;
    tmp_r <= tmp_nxt;
  end

  // pending ranges are disjoint and hold at least two elements each
  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= CNT_W'(rqs_pkg::MAX_ITEMS / 2))
    else $error("range stack deeper than half the store");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(rqs_pkg::MAX_ITEMS))
    else $error("element count beyond capacity");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_acc && out_valid))
    else $error("input taken while a result is offered");

  a_set_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_acc && out_data.final_res) |=> (cnt_r == '0 && !ovf_r && !in_stall))
    else $error("set not cleared after final transaction");

  a_out_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("result offered from an empty set");

endmodule
